@@ hw/rtl/lsd_pkg.sv @@
// Shared types, widths and helpers for the least-squares linear detrend block.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package lsd_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int SAMPLE_BITS = 24;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

    // Record sums.
    localparam int VSUM_W  = 31;
    localparam int IVSUM_W = 37;
    localparam int SX_W    = 11;
    localparam int SXX_W   = 17;

    // Fit terms.
    localparam int D_W   = 22;
    localparam int P_W   = 48;
    localparam int Q_W   = 52;
    localparam int NUM_W = 56;

    // Serial divider.
    localparam int DIV_W     = 64;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Result fields.
    localparam int DET_BITS   = 25;
    localparam int SLOPE_BITS = 40;
    localparam int ICPT_BITS  = 32;
    localparam int SLOPE_SH   = 16;
    localparam int ICPT_SH    = 8;
    localparam int OUT_DATA_W = ((DET_BITS + SLOPE_BITS + ICPT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [CNT_W-1:0]          n;
        logic signed [VSUM_W-1:0]  sy;
        logic signed [IVSUM_W-1:0] sxy;
        logic [SX_W-1:0]           sx;
        logic [SXX_W-1:0]          sxx;
    } lsd_job_t;

    typedef struct packed {
        logic             go;
        logic [DIV_W-1:0] num;
        logic [D_W-1:0]   den;
    } lsd_div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } lsd_div_res_t;

    // Applies the sign to a magnitude and saturates to a signed field of the given width.
    function automatic logic [63:0] lsd_sat(input logic neg, input logic [63:0] mag,
                                            input int bits);
        logic [63:0] hi;
        logic [63:0] res;
        hi = (64'd1 << (bits - 1)) - 64'd1;
        if (!neg) begin
            res = (mag > hi) ? hi : mag;
        end else begin
            res = (mag > hi + 64'd1) ? (64'd0 - (hi + 64'd1)) : (64'd0 - mag);
        end
        return res;
    endfunction

endpackage

@@ hw/rtl/least_squares_linear_detrend.sv @@
// Samples load at one per cycle, while the input is not stalled, into a 64-entry store
// while the record sums build up. The sample marked last starts the fit, and the input
// stalls until every detrended result of that record has been taken. The fit multiplies
// the record sums into the fit terms, then slope and intercept each pass through the
// shared 64-step serial divider, and each detrended result takes one more divider pass.
// A record shorter than two samples yields one error result.
//
// Top level of the detrend block; depends on lsd_pkg, lsd_front, lsd_queue, lsd_div
// and lsd_back.
`timescale 1ns / 1ps

module least_squares_linear_detrend
    import lsd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [SAMPLE_BITS-1:0] s_axis_tdata,   // [23:0] sample
    input  logic                   s_axis_tlast,   // final_sample
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // [24:0] detrended, [64:25] slope,
                                                   // [96:65] intercept, rest zero
    output logic                   m_axis_tlast,   // run_end
    output logic [0:0]             m_axis_tuser    // [0] fit_error
);

    lsd_job_t               push_job;
    lsd_job_t               pop_job;
    logic                   job_push;
    logic                   job_full;
    logic                   job_pop;
    logic                   job_valid;
    logic                   rec_done;
    logic [ADDR_W-1:0]      rd_addr;
    logic [SAMPLE_BITS-1:0] rd_data;
    lsd_div_req_t           div_req;
    lsd_div_res_t           div_res;

    lsd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .job           (push_job),
        .job_push      (job_push),
        .job_full      (job_full),
        .rec_done      (rec_done),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data)
    );

    lsd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_job  (push_job),
        .full      (job_full),
        .pop       (job_pop),
        .pop_job   (pop_job),
        .not_empty (job_valid)
    );

    lsd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    lsd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job           (pop_job),
        .job_valid     (job_valid),
        .job_pop       (job_pop),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .div_req       (div_req),
        .div_res       (div_res),
        .rec_done      (rec_done),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

@@ hw/rtl/lsd_queue.sv @@
// Two-entry queue of fit jobs between the loading front end and the fit back end.
// Depends on lsd_pkg.
`timescale 1ns / 1ps

module lsd_queue
    import lsd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  lsd_job_t push_job,
    output logic     full,
    input  logic     pop,
    output lsd_job_t pop_job,
    output logic     not_empty
);

    lsd_job_t   mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign pop_job   = mem[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !full && !(pop && not_empty)) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && not_empty && !(push && !full)) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop && not_empty) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_next;
        end
    end

endmodule

@@ hw/rtl/lsd_front.sv @@
// Front end: takes samples, stores them and keeps the running record sums.
// On the last sample it posts a fit job. Depends on lsd_pkg.
`timescale 1ns / 1ps

module lsd_front
    import lsd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [SAMPLE_BITS-1:0] s_axis_tdata,
    input  logic                   s_axis_tlast,
    output lsd_job_t               job,
    output logic                   job_push,
    input  logic                   job_full,
    input  logic                   rec_done,
    input  logic [ADDR_W-1:0]      rd_addr,
    output logic [SAMPLE_BITS-1:0] rd_data
);

    logic [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];

    logic [CNT_W-1:0]          cnt_reg;
    logic signed [VSUM_W-1:0]  sy_reg;
    logic signed [IVSUM_W-1:0] sxy_reg;
    logic [SX_W-1:0]           sx_reg;
    logic [SXX_W-1:0]          sxx_reg;
    logic                      busy_reg;
    logic [SAMPLE_BITS-1:0]    rd_data_reg;

    logic                                 accept;
    logic                                 room;
    logic signed [SAMPLE_BITS-1:0]        y;
    logic signed [CNT_W+SAMPLE_BITS:0]    iy;
    lsd_job_t                             upd;

    // Stall while a record is still being fitted, since its samples live in the store, or while the job queue is full.
    assign s_axis_tready = !busy_reg && !job_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign room          = (cnt_reg < CNT_W'(MAX_SAMPLES));
    assign y             = $signed(s_axis_tdata);
    assign iy            = $signed({1'b0, cnt_reg}) * y;

    always_comb
    begin
        upd.n   = cnt_reg;
        upd.sy  = sy_reg;
        upd.sxy = sxy_reg;
        upd.sx  = sx_reg;
        upd.sxx = sxx_reg;
        if (room) begin
            upd.n   = cnt_reg + CNT_W'(1);
            upd.sy  = sy_reg + VSUM_W'(y);
            upd.sxy = sxy_reg + IVSUM_W'(iy);
            upd.sx  = sx_reg + SX_W'(cnt_reg);
            upd.sxx = sxx_reg + SXX_W'(cnt_reg * cnt_reg);
        end
    end

    assign job      = upd;
    assign job_push = accept && s_axis_tlast;
    assign rd_data  = rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (accept && room) begin
            mem[cnt_reg[ADDR_W-1:0]] <= s_axis_tdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            sy_reg   <= '0;
            sxy_reg  <= '0;
            sx_reg   <= '0;
            sxx_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            if (accept && s_axis_tlast) begin
                cnt_reg  <= '0;
                sy_reg   <= '0;
                sxy_reg  <= '0;
                sx_reg   <= '0;
                sxx_reg  <= '0;
                busy_reg <= 1'b1;
            end else begin
                if (accept) begin
                    cnt_reg <= upd.n;
                    sy_reg  <= upd.sy;
                    sxy_reg <= upd.sxy;
                    sx_reg  <= upd.sx;
                    sxx_reg <= upd.sxx;
                end
                if (rec_done) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule

@@ hw/rtl/lsd_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on lsd_pkg.
`timescale 1ns / 1ps

module lsd_div
    import lsd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  lsd_div_req_t req,
    output lsd_div_res_t res
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [D_W-1:0]       rem_reg;
    logic [D_W-1:0]       den_reg;
    logic [DIV_W-1:0]     quo_reg;

    logic [D_W:0] trial;
    logic         fits;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    assign res.done = done_reg;
    assign res.quot = quo_reg;

    always_ff @(posedge clk)
    begin
        if (req.go) begin
            quo_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? D_W'(trial - {1'b0, den_reg}) : D_W'(trial);
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.go) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

@@ hw/rtl/lsd_back.sv @@
// Back end: forms the fit terms of a queued record, divides out slope and intercept,
// then streams out each stored sample minus the fitted line. Depends on lsd_pkg.
`timescale 1ns / 1ps

module lsd_back
    import lsd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  lsd_job_t               job,
    input  logic                   job_valid,
    output logic                   job_pop,
    output logic [ADDR_W-1:0]      rd_addr,
    input  logic [SAMPLE_BITS-1:0] rd_data,
    output lsd_div_req_t           div_req,
    input  lsd_div_res_t           div_res,
    output logic                   rec_done,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                   m_axis_tlast,
    output logic [0:0]             m_axis_tuser
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_DPQ, S_SLOPE_GO, S_SLOPE_WAIT, S_ICPT_GO, S_ICPT_WAIT,
        S_RD, S_PRD, S_NUM, S_DET_GO, S_DET_WAIT, S_OUT
    } state_t;

    state_t state_reg;

    lsd_job_t                          job_reg;
    logic [CNT_W+SXX_W-1:0]            nsxx_reg;
    logic [2*SX_W-1:0]                 sxsx_reg;
    logic signed [CNT_W+IVSUM_W:0]     nsxy_reg;
    logic signed [SX_W+VSUM_W:0]       sxsy_reg;
    logic signed [SXX_W+VSUM_W:0]      sxxsy_reg;
    logic signed [SX_W+IVSUM_W:0]      sxsxy_reg;
    logic [D_W-1:0]                    d_reg;
    logic signed [P_W-1:0]             p_reg;
    logic signed [Q_W-1:0]             q_reg;
    logic signed [SAMPLE_BITS+D_W:0]   yd_reg;
    logic signed [P_W+ADDR_W:0]        pi_reg;
    logic signed [NUM_W-1:0]           num_reg;
    logic [ADDR_W-1:0]                 idx_reg;
    logic [SLOPE_BITS-1:0]             slope_reg;
    logic [ICPT_BITS-1:0]              icpt_reg;
    logic [DET_BITS-1:0]               det_reg;
    logic                              last_reg;
    logic                              err_reg;

    logic [P_W-1:0]   p_abs;
    logic [Q_W-1:0]   q_abs;
    logic [NUM_W-1:0] num_abs;
    logic [63:0]      sat_slope;
    logic [63:0]      sat_icpt;
    logic [63:0]      sat_det;

    assign p_abs   = p_reg[P_W-1] ? P_W'(-p_reg) : P_W'(p_reg);
    assign q_abs   = q_reg[Q_W-1] ? Q_W'(-q_reg) : Q_W'(q_reg);
    assign num_abs = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);

    assign sat_slope = lsd_sat(p_reg[P_W-1], div_res.quot, SLOPE_BITS);
    assign sat_icpt  = lsd_sat(q_reg[Q_W-1], div_res.quot, ICPT_BITS);
    assign sat_det   = lsd_sat(num_reg[NUM_W-1], div_res.quot, DET_BITS);

    // Adding half the divisor before a floor division rounds to nearest, ties away from zero.
    always_comb
    begin
        div_req.go  = 1'b0;
        div_req.den = d_reg;
        div_req.num = DIV_W'(d_reg >> 1);
        case (state_reg)
            S_SLOPE_GO:
            begin
                div_req.go  = 1'b1;
                div_req.num = (DIV_W'(p_abs) << SLOPE_SH) + DIV_W'(d_reg >> 1);
            end
            S_ICPT_GO:
            begin
                div_req.go  = 1'b1;
                div_req.num = (DIV_W'(q_abs) << ICPT_SH) + DIV_W'(d_reg >> 1);
            end
            S_DET_GO:
            begin
                div_req.go  = 1'b1;
                div_req.num = DIV_W'(num_abs) + DIV_W'(d_reg >> 1);
            end
            default:
            begin
                div_req.go = 1'b0;
            end
        endcase
    end

    assign job_pop       = (state_reg == S_IDLE) && job_valid;
    assign rd_addr       = idx_reg;
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tlast  = last_reg;
    assign m_axis_tuser  = err_reg;
    assign m_axis_tdata  = OUT_DATA_W'({icpt_reg, slope_reg, det_reg});
    assign rec_done      = (state_reg == S_OUT) && m_axis_tready && last_reg;

    always_ff @(posedge clk)
    begin
        nsxx_reg  <= job_reg.n * job_reg.sxx;
        sxsx_reg  <= job_reg.sx * job_reg.sx;
        nsxy_reg  <= $signed({1'b0, job_reg.n}) * job_reg.sxy;
        sxsy_reg  <= $signed({1'b0, job_reg.sx}) * job_reg.sy;
        sxxsy_reg <= $signed({1'b0, job_reg.sxx}) * job_reg.sy;
        sxsxy_reg <= $signed({1'b0, job_reg.sx}) * job_reg.sxy;
        yd_reg    <= $signed(rd_data) * $signed({1'b0, d_reg});
        pi_reg    <= p_reg * $signed({1'b0, idx_reg});
        if (state_reg == S_IDLE && job_valid) begin
            job_reg <= job;
        end
        if (state_reg == S_DPQ) begin
            d_reg <= D_W'(nsxx_reg - (CNT_W+SXX_W)'(sxsx_reg));
            p_reg <= P_W'(nsxy_reg) - P_W'(sxsy_reg);
            q_reg <= Q_W'(sxxsy_reg) - Q_W'(sxsxy_reg);
        end
        if (state_reg == S_NUM) begin
            num_reg <= NUM_W'(yd_reg) - NUM_W'(pi_reg) - NUM_W'(q_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            slope_reg <= '0;
            icpt_reg  <= '0;
            det_reg   <= '0;
            last_reg  <= 1'b0;
            err_reg   <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_valid) begin
                        idx_reg <= '0;
                        if (job.n < CNT_W'(2)) begin
                            slope_reg <= '0;
                            icpt_reg  <= '0;
                            det_reg   <= '0;
                            last_reg  <= 1'b1;
                            err_reg   <= 1'b1;
                            state_reg <= S_OUT;
                        end else begin
                            err_reg   <= 1'b0;
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL:        state_reg <= S_DPQ;
                S_DPQ:        state_reg <= S_SLOPE_GO;
                S_SLOPE_GO:   state_reg <= S_SLOPE_WAIT;
                S_SLOPE_WAIT:
                begin
                    if (div_res.done) begin
                        slope_reg <= sat_slope[SLOPE_BITS-1:0];
                        state_reg <= S_ICPT_GO;
                    end
                end
                S_ICPT_GO:    state_reg <= S_ICPT_WAIT;
                S_ICPT_WAIT:
                begin
                    if (div_res.done) begin
                        icpt_reg  <= sat_icpt[ICPT_BITS-1:0];
                        state_reg <= S_RD;
                    end
                end
                S_RD:         state_reg <= S_PRD;
                S_PRD:        state_reg <= S_NUM;
                S_NUM:        state_reg <= S_DET_GO;
                S_DET_GO:     state_reg <= S_DET_WAIT;
                S_DET_WAIT:
                begin
                    if (div_res.done) begin
                        det_reg   <= sat_det[DET_BITS-1:0];
                        last_reg  <= ({1'b0, idx_reg} + CNT_W'(1) == job_reg.n);
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (m_axis_tready) begin
                        if (last_reg) begin
                            state_reg <= S_IDLE;
                        end else begin
                            idx_reg   <= idx_reg + ADDR_W'(1);
                            state_reg <= S_RD;
                        end
                    end
                end
                default:      state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
